>>> design/amx_pkg.sv
// Package for the ADSR wavetable voice mixer.
// Holds the codes, enums, command structs and the sine table function.
// No dependencies; compiled first.
package amx_pkg;

    localparam int VOICES_DEF = 8;
    localparam int RATE_W     = 16;
    localparam int LEVEL_MAX  = 65535;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

    localparam logic [15:0] ATTACK_RST  = 16'd200;
    localparam logic [15:0] DECAY_RST   = 16'd30;
    localparam logic [15:0] SUSTAIN_RST = 16'd32000;
    localparam logic [15:0] RELEASE_RST = 16'd10;
    localparam logic [15:0] LFSR_SEED   = 16'hACE1;

    typedef enum logic [1:0] {
        FN_TICK    = 2'd0,
        FN_NOTE_ON = 2'd1,
        FN_KEY_OFF = 2'd2,
        FN_UNUSED  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OFF     = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    typedef enum logic [2:0] {
        WV_SINE   = 3'd0,
        WV_SAW    = 3'd1,
        WV_SQUARE = 3'd2,
        WV_TRI    = 3'd3,
        WV_NOISE  = 3'd4
    } t_wave;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENV,
        S_MUL,
        S_GAIN,
        S_ACC,
        S_DINIT,
        S_DIV,
        S_DONE
    } t_ctrl_state;

    typedef struct packed {
        logic note_on;
        logic key_off;
        logic clr_mix;
        logic env_step;
        logic mul;
        logic gain;
        logic acc;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    // Rounded 127.5*sin(k*pi/128) for one quarter period; the last entry marks the peak.
    localparam logic [7:0] QSINE [0:64] = '{
        8'd0, 8'd3, 8'd6, 8'd9, 8'd12, 8'd16, 8'd19, 8'd22, 8'd25, 8'd28,
        8'd31, 8'd34, 8'd37, 8'd40, 8'd43, 8'd46, 8'd49, 8'd52, 8'd55, 8'd57,
        8'd60, 8'd63, 8'd66, 8'd68, 8'd71, 8'd73, 8'd76, 8'd78, 8'd81, 8'd83,
        8'd86, 8'd88, 8'd90, 8'd92, 8'd94, 8'd97, 8'd99, 8'd101, 8'd102, 8'd104,
        8'd106, 8'd108, 8'd109, 8'd111, 8'd112, 8'd114, 8'd115, 8'd117, 8'd118, 8'd119,
        8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd124, 8'd125, 8'd126, 8'd126, 8'd127,
        8'd127, 8'd127, 8'd127, 8'd127, 8'd128
    };

    function automatic logic [7:0] sine_at(input logic [7:0] i);
        logic [8:0] k9;
        logic [7:0] q;
        logic [8:0] val;
        if (i <= 8'd64) begin
            k9 = {1'b0, i};
        end else if (i < 8'd128) begin
            k9 = 9'd128 - {1'b0, i};
        end else if (i <= 8'd192) begin
            k9 = {1'b0, i} - 9'd128;
        end else begin
            k9 = 9'd256 - {1'b0, i};
        end
        q = QSINE[k9[6:0]];
        if (i < 8'd128) begin
            val = 9'd127 + {1'b0, q};
        end else if (q > 8'd127) begin
            val = 9'd0;
        end else begin
            val = 9'd127 - {1'b0, q};
        end
        return val[7:0];
    endfunction

endpackage

>>> design/amx_if.sv
// Channel interfaces of the voice mixer: input items, result items, register writes.
// Depends on nothing.
interface amx_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [2:0]  channel;
    logic [2:0]  wave_type;
    logic [15:0] phase_step;
    logic [8:0]  volume;
    modport source (output valid, func, channel, wave_type, phase_step, volume, input ready);
    modport sink (input valid, func, channel, wave_type, phase_step, volume, output ready);
endinterface

interface amx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;
    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

interface amx_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> design/amx_ctrl.sv
// Controller of the voice mixer: decodes items and sequences the voice walk and divide.
// Depends on amx_pkg.
module amx_ctrl #(
    parameter int VOICES = amx_pkg::VOICES_DEF,
    parameter int VW     = (VOICES > 1) ? $clog2(VOICES) : 1,
    parameter int MIXW   = $clog2(VOICES) + 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_func,
    output logic           o_in_ready,
    input  amx_pkg::t_status i_status,
    output amx_pkg::t_cmd  o_cmd,
    output logic [VW-1:0]  o_voice
);
    import amx_pkg::*;

    localparam int CW = $clog2(VOICES + MIXW + 1);

    t_ctrl_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_voice = r_cnt[VW-1:0];

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (t_func'(i_func))
                        FN_NOTE_ON: o_cmd.note_on = 1'b1;
                        FN_KEY_OFF: o_cmd.key_off = 1'b1;
                        FN_TICK: begin
                            o_cmd.clr_mix = 1'b1;
                            n_cnt         = '0;
                            n_state       = S_ENV;
                        end
                        default: ;
                    endcase
                end
            end
            S_ENV: begin
                o_cmd.env_step = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_cnt == CW'(VOICES - 1)) begin
                    n_state = S_DINIT;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_ENV;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_voice_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENV) |-> (r_cnt < CW'(VOICES)))
        else $error("voice counter beyond last voice");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DONE))
        else $error("divide did not finish in one cycle");
`endif

endmodule

>>> design/amx_datapath.sv
// Datapath of the voice mixer: voice state, envelopes, waves, gain, mix, divide, output.
// Depends on amx_pkg; driven by amx_ctrl commands.
module amx_datapath #(
    parameter int VOICES = amx_pkg::VOICES_DEF,
    parameter int VW     = (VOICES > 1) ? $clog2(VOICES) : 1,
    parameter int MIXW   = $clog2(VOICES) + 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  amx_pkg::t_cmd   i_cmd,
    input  logic [VW-1:0]   i_voice,
    output amx_pkg::t_status o_status,
    input  logic [2:0]      i_channel,
    input  logic [2:0]      i_wave_type,
    input  logic [15:0]     i_phase_step,
    input  logic [8:0]      i_volume,
    input  logic            i_cfg_valid,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [7:0]      o_sample
);
    import amx_pkg::*;

    // Reciprocal of the voice count, exact for every magnitude below 2**MIXW.
    localparam int     DW      = $clog2(VOICES);
    localparam int     SH      = MIXW + DW;
    localparam longint RECIP_L = ((longint'(1) << SH) + longint'(VOICES) - 1)
                                 / longint'(VOICES);
    localparam logic [SH:0] RECIP = (SH+1)'(RECIP_L);

    logic [15:0] r_att, r_dec, r_sus, r_rel;
    t_stage      r_stage [VOICES];
    logic [15:0] r_env   [VOICES];
    logic [15:0] r_phase [VOICES];
    logic [15:0] r_step  [VOICES];
    logic [2:0]  r_wave  [VOICES];
    logic [8:0]  r_vol   [VOICES];
    logic [63:0] r_rates [VOICES];
    logic [15:0] r_lfsr;

    logic               r_act;
    logic [15:0]        r_lvl;
    logic [8:0]         r_vsel;
    logic signed [8:0]  r_raw;
    logic [24:0]        r_prod;
    logic [8:0]         r_gain;
    logic signed [MIXW-1:0] r_mix;
    logic               r_neg;
    logic [MIXW-1:0]    r_quo;
    logic               r_out_valid;
    logic [7:0]         r_sample;

    logic [VW-1:0] ch_idx;
    logic          ch_ok;

    // Envelope step and wave for the voice being walked.
    t_stage      n_stage;
    logic [15:0] n_lvl;
    logic [15:0] n_lfsr;
    logic signed [8:0] n_raw;
    logic [63:0] rt;
    logic [16:0] up;
    logic signed [17:0] dn;
    logic [7:0]  idx, tri_i;
    logic        fb;

    assign ch_idx = VW'(i_channel);
    assign ch_ok  = ({2'b0, i_channel} < 5'(VOICES)) || (VOICES > 7);

    always_comb begin
        rt      = r_rates[i_voice];
        n_stage = r_stage[i_voice];
        n_lvl   = r_env[i_voice];
        up      = {1'b0, r_env[i_voice]} + {1'b0, rt[15:0]};
        dn      = '0;
        case (r_stage[i_voice])
            ST_ATTACK: begin
                if (up >= 17'(LEVEL_MAX)) begin
                    n_lvl   = 16'hFFFF;
                    n_stage = ST_DECAY;
                end else begin
                    n_lvl = up[15:0];
                end
            end
            ST_DECAY: begin
                dn = $signed({2'b0, r_env[i_voice]}) - $signed({2'b0, rt[31:16]});
                if (dn <= $signed({2'b0, rt[47:32]})) begin
                    n_lvl   = rt[47:32];
                    n_stage = ST_SUSTAIN;
                end else begin
                    n_lvl = dn[15:0];
                end
            end
            ST_SUSTAIN: n_lvl = rt[47:32];
            ST_RELEASE: begin
                dn = $signed({2'b0, r_env[i_voice]}) - $signed({2'b0, rt[63:48]});
                if (dn <= 18'sd0) begin
                    n_lvl   = '0;
                    n_stage = ST_OFF;
                end else begin
                    n_lvl = dn[15:0];
                end
            end
            default: ;
        endcase

        idx    = r_phase[i_voice][15:8];
        tri_i  = (idx > 8'd127) ? (8'd255 - idx) : idx;
        fb     = r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5];
        n_lfsr = r_lfsr;
        case (r_wave[i_voice])
            WV_SINE:   n_raw = $signed({1'b0, sine_at(idx)}) - 9'sd128;
            WV_SAW:    n_raw = $signed({1'b0, idx}) - 9'sd128;
            WV_SQUARE: n_raw = r_phase[i_voice][15] ? 9'sd127 : -9'sd128;
            WV_TRI:    n_raw = $signed({tri_i, 1'b0}) - 9'sd128;
            WV_NOISE: begin
                n_lfsr = {fb, r_lfsr[15:1]};
                n_raw  = $signed({1'b0, n_lfsr[7:0]}) - 9'sd128;
            end
            default:   n_raw = '0;
        endcase
    end

    // Voice state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att  <= ATTACK_RST;
            r_dec  <= DECAY_RST;
            r_sus  <= SUSTAIN_RST;
            r_rel  <= RELEASE_RST;
            r_lfsr <= LFSR_SEED;
            for (int v = 0; v < VOICES; v++) begin
                r_stage[v] <= ST_OFF;
                r_env[v]   <= '0;
                r_phase[v] <= '0;
                r_step[v]  <= '0;
                r_wave[v]  <= '0;
                r_vol[v]   <= '0;
                r_rates[v] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ATTACK:  r_att <= i_cfg_data;
                    CFG_DECAY:   r_dec <= i_cfg_data;
                    CFG_SUSTAIN: r_sus <= i_cfg_data;
                    CFG_RELEASE: r_rel <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.note_on && ch_ok) begin
                r_wave[ch_idx]  <= i_wave_type;
                r_step[ch_idx]  <= i_phase_step;
                r_vol[ch_idx]   <= i_volume;
                r_phase[ch_idx] <= '0;
                r_stage[ch_idx] <= ST_ATTACK;
                r_rates[ch_idx] <= {r_rel, r_sus, r_dec, r_att};
            end
            if (i_cmd.key_off && ch_ok && r_stage[ch_idx] != ST_OFF) begin
                r_stage[ch_idx] <= ST_RELEASE;
            end
            if (i_cmd.env_step && r_stage[i_voice] != ST_OFF) begin
                r_stage[i_voice] <= n_stage;
                r_env[i_voice]   <= n_lvl;
                r_phase[i_voice] <= r_phase[i_voice] + r_step[i_voice];
                r_lfsr           <= n_lfsr;
            end
        end
    end

    // Per-voice arithmetic pipeline and the divide by the voice count.
    logic [24:0] p16;
    logic signed [18:0] term;
    logic [MIXW+SH:0] qprod;
    logic signed [MIXW+1:0] fin;

    assign p16   = r_prod + {16'b0, r_prod[24:16]} + 25'd1;
    assign term  = (r_raw * $signed({1'b0, r_gain})) >>> 8;
    assign qprod = r_quo * RECIP;

    always_ff @(posedge i_clk) begin
        if (i_cmd.env_step) begin
            r_act  <= (r_stage[i_voice] != ST_OFF);
            r_lvl  <= n_lvl;
            r_vsel <= r_vol[i_voice];
            r_raw  <= n_raw;
        end
        if (i_cmd.mul) begin
            r_prod <= r_lvl * r_vsel;
        end
        if (i_cmd.gain) begin
            // Floor of the product over 65535, exact for these widths.
            r_gain <= p16[24:16];
        end
        if (i_cmd.clr_mix) begin
            r_mix <= '0;
        end else if (i_cmd.acc && r_act) begin
            r_mix <= r_mix + MIXW'(term);
        end
        if (i_cmd.div_init) begin
            r_neg <= r_mix[MIXW-1];
            r_quo <= r_mix[MIXW-1] ? MIXW'(-r_mix) : MIXW'(r_mix);
        end else if (i_cmd.div_step) begin
            r_quo <= qprod[SH +: MIXW];
        end
    end

    assign fin = (r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo}))
                 + (MIXW+2)'(128);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (fin < 0) begin
                r_sample <= 8'd0;
            end else if (fin > (MIXW+2)'(255)) begin
                r_sample <= 8'd255;
            end else begin
                r_sample <= fin[7:0];
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_sample          = r_sample;

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded sample not presented");
    a_off_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage[0] == ST_OFF) |-> (r_env[0] == 16'd0))
        else $error("silent voice holds an envelope level");
`endif

endmodule

>>> design/adsr_wavetable_voice_mixer.sv
// Multi-voice ADSR wavetable mixer. A note-on or key-off item is taken without leaving the idle
// state. A sample tick walks the voices one after another through the envelope, multiply, gain
// and accumulate steps, then divides the sum by the voice count with a reciprocal multiply and
// waits until the output register is free. The finished sample sits in an output register, and
// the next item is taken while it waits.
module adsr_wavetable_voice_mixer #(
    parameter int VOICES = amx_pkg::VOICES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    amx_in_if.sink        i_in_ch,
    amx_out_if.source     o_out_ch,
    amx_cfg_if.sink       i_cfg_ch
);
    import amx_pkg::*;

    localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MIXW = $clog2(VOICES) + 10;

    t_cmd          cmd;
    t_status       status;
    logic [VW-1:0] voice;

    assign i_cfg_ch.ready = 1'b1;

    amx_ctrl #(.VOICES(VOICES), .VW(VW), .MIXW(MIXW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_func     (i_in_ch.func),
        .o_in_ready (i_in_ch.ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_voice    (voice)
    );

    amx_datapath #(.VOICES(VOICES), .VW(VW), .MIXW(MIXW)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_voice      (voice),
        .o_status     (status),
        .i_channel    (i_in_ch.channel),
        .i_wave_type  (i_in_ch.wave_type),
        .i_phase_step (i_in_ch.phase_step),
        .i_volume     (i_in_ch.volume),
        .i_cfg_valid  (i_cfg_ch.valid),
        .i_cfg_index  (i_cfg_ch.index),
        .i_cfg_data   (i_cfg_ch.data),
        .i_out_ready  (o_out_ch.ready),
        .o_out_valid  (o_out_ch.valid),
        .o_sample     (o_out_ch.sample)
    );

endmodule

>>> tb/adsr_wavetable_voice_mixer_test.sv
// Self-checking testbench for the ADSR wavetable voice mixer.
// Needs amx_pkg, the channel interfaces and the mixer RTL. A scoreboard class predicts
// each mixed sample from the accepted items; plain tasks drive the input and register channels.
`timescale 1ns / 1ps

module adsr_wavetable_voice_mixer_test;
    import amx_pkg::*;

    localparam int NVOICE    = VOICES_DEF;
    localparam int TICK_LAT  = 4 * NVOICE + 13 + 16;
    localparam int STALL_MAX = 5000;

    class mix_scoreboard;
        logic [15:0] atk_reg, dec_reg, sus_reg, rel_reg;
        bit          active [NVOICE];
        t_stage      stage [NVOICE];
        logic [15:0] level [NVOICE];
        logic [15:0] ph [NVOICE];
        logic [15:0] step [NVOICE];
        logic [2:0]  wave [NVOICE];
        logic [8:0]  vol [NVOICE];
        logic [15:0] v_atk [NVOICE], v_dec [NVOICE], v_sus [NVOICE], v_rel [NVOICE];
        logic [15:0] lfsr;
        logic [7:0]  sine_tab [256];
        logic [7:0]  pending_samples [$];
        int          errors;

        function new();
            int k, val;
            atk_reg = ATTACK_RST;
            dec_reg = DECAY_RST;
            sus_reg = SUSTAIN_RST;
            rel_reg = RELEASE_RST;
            lfsr    = LFSR_SEED;
            errors  = 0;
            for (int v = 0; v < NVOICE; v++) begin
                active[v] = 0; stage[v] = ST_OFF; level[v] = 0; ph[v] = 0;
                step[v] = 0; wave[v] = 0; vol[v] = 0;
                v_atk[v] = 0; v_dec[v] = 0; v_sus[v] = 0; v_rel[v] = 0;
            end
            for (int i = 0; i < 256; i++) begin
                if (i <= 64) k = i;
                else if (i < 128) k = 128 - i;
                else if (i <= 192) k = i - 128;
                else k = 256 - i;
                val = (i < 128) ? 127 + int'(QSINE[k]) : 127 - int'(QSINE[k]);
                if (val < 0) val = 0;
                sine_tab[i] = val[7:0];
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_ATTACK:  atk_reg = data;
                CFG_DECAY:   dec_reg = data;
                CFG_SUSTAIN: sus_reg = data;
                CFG_RELEASE: rel_reg = data;
                default: ;
            endcase
        endfunction

        function int wave_value(int v);
            int idx;
            logic bit0;
            idx = ph[v][15:8];
            case (wave[v])
                WV_SINE:   return int'(sine_tab[idx]) - 128;
                WV_SAW:    return idx - 128;
                WV_SQUARE: return ph[v][15] ? 127 : -128;
                WV_TRI: begin
                    if (idx > 127) idx = 255 - idx;
                    return idx * 2 - 128;
                end
                WV_NOISE: begin
                    bit0 = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
                    lfsr = {bit0, lfsr[15:1]};
                    return int'(lfsr[7:0]) - 128;
                end
                default: return 0;
            endcase
        endfunction

        function void advance_envelope(int v);
            int lvl;
            lvl = level[v];
            case (stage[v])
                ST_ATTACK: begin
                    lvl += v_atk[v];
                    if (lvl >= LEVEL_MAX) begin
                        lvl = LEVEL_MAX; stage[v] = ST_DECAY;
                    end
                end
                ST_DECAY: begin
                    lvl -= v_dec[v];
                    if (lvl <= int'(v_sus[v])) begin
                        lvl = v_sus[v]; stage[v] = ST_SUSTAIN;
                    end
                end
                ST_SUSTAIN: lvl = v_sus[v];
                ST_RELEASE: begin
                    lvl -= v_rel[v];
                    if (lvl <= 0) begin
                        lvl = 0; stage[v] = ST_OFF; active[v] = 0;
                    end
                end
                default: ;
            endcase
            level[v] = lvl[15:0];
        endfunction

        function void note_item(logic [1:0] fn, logic [2:0] ch, logic [2:0] wv,
                                logic [15:0] st, logic [8:0] vl);
            int mix, gain;
            case (fn)
                FN_NOTE_ON: if (ch < NVOICE) begin
                    wave[ch] = wv; step[ch] = st; vol[ch] = vl; ph[ch] = 0;
                    active[ch] = 1; stage[ch] = ST_ATTACK;
                    v_atk[ch] = atk_reg; v_dec[ch] = dec_reg;
                    v_sus[ch] = sus_reg; v_rel[ch] = rel_reg;
                end
                FN_KEY_OFF: if (ch < NVOICE && stage[ch] != ST_OFF) stage[ch] = ST_RELEASE;
                FN_TICK: begin
                    mix = 0;
                    for (int v = 0; v < NVOICE; v++) begin
                        if (!active[v]) continue;
                        advance_envelope(v);
                        gain = int'((32'(level[v]) * 32'(vol[v])) / 32'd65535);
                        mix += (wave_value(v) * gain) >>> 8;
                        ph[v] = ph[v] + step[v];
                    end
                    mix = mix / NVOICE + 128;
                    if (mix > 255) mix = 255;
                    if (mix < 0) mix = 0;
                    pending_samples.push_back(mix[7:0]);
                end
                default: ;
            endcase
        endfunction

        function void check_sample(logic [7:0] got);
            logic [7:0] want;
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected sample item, actual %0d", $time, got);
                errors++;
                return;
            end
            want = pending_samples.pop_front();
            if (got !== want) begin
                $display("%0t: sample mismatch, expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    amx_in_if  in_ch();
    amx_out_if out_ch();
    amx_cfg_if cfg_ch();
    mix_scoreboard sb;
    int burst_left;
    int idle_cycles;

    adsr_wavetable_voice_mixer #(.VOICES(NVOICE)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_ch(in_ch), .o_out_ch(out_ch), .i_cfg_ch(cfg_ch)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: alternates stretches of steady ready with stretches of random stalls.
    always @(posedge i_clk) begin : rx_stall
        int mode_cnt;
        int mode;
        if (mode_cnt == 0) begin
            mode_cnt = $urandom_range(50, 400);
            mode = $urandom_range(0, 2);
        end
        mode_cnt--;
        case (mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            default: out_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) sb.check_sample(out_ch.sample);
            if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                sb.note_item(in_ch.func, in_ch.channel, in_ch.wave_type,
                             in_ch.phase_step, in_ch.volume);
            if ((out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (in_ch.valid && in_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_MAX) begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    task automatic put_item(t_func fn, logic [2:0] ch, logic [2:0] wv,
                            logic [15:0] st, logic [8:0] vl);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.func       <= fn;
        in_ch.channel    <= ch;
        in_ch.wave_type  <= wv;
        in_ch.phase_step <= st;
        in_ch.volume     <= vl;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Lets every expected sample arrive, then gives the block time to settle.
    task automatic drain_samples();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending_samples.size() != 0);
        repeat (TICK_LAT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic write_all(logic [15:0] atk, logic [15:0] dec, logic [15:0] sus,
                             logic [15:0] rel);
        write_reg(CFG_ATTACK, atk);
        write_reg(CFG_DECAY, dec);
        write_reg(CFG_SUSTAIN, sus);
        write_reg(CFG_RELEASE, rel);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_items(int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                put_item(FN_TICK, 3'($urandom), 3'($urandom), 16'($urandom), 9'($urandom));
            end else if (sel < 80) begin
                put_item(FN_NOTE_ON, 3'($urandom),
                         ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4)),
                         pick16(),
                         ($urandom_range(0, 7) == 0) ? 9'($urandom)
                                                     : 9'($urandom_range(0, 256)));
            end else if (sel < 96) begin
                put_item(FN_KEY_OFF, 3'($urandom), 3'($urandom), 16'($urandom), 9'($urandom));
            end else begin
                put_item(FN_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom), 9'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        burst_left = 0;
        idle_cycles = 0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.func <= FN_TICK;
        in_ch.channel <= '0;
        in_ch.wave_type <= '0;
        in_ch.phase_step <= '0;
        in_ch.volume <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_ATTACK;
        cfg_ch.data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset register values.
        put_item(FN_TICK, 3'd0, 3'd0, 16'd0, 9'd0);
        put_item(FN_KEY_OFF, 3'd7, 3'd0, 16'd0, 9'd0);
        put_item(FN_UNUSED, 3'd7, 3'd7, 16'hFFFF, 9'h1FF);
        put_item(FN_NOTE_ON, 3'd0, WV_SINE, 16'd1000, 9'd256);
        put_item(FN_NOTE_ON, 3'd1, WV_SAW, 16'hFFFF, 9'd256);
        put_item(FN_NOTE_ON, 3'd2, WV_SQUARE, 16'd0, 9'd511);
        put_item(FN_NOTE_ON, 3'd3, WV_TRI, 16'd4096, 9'd128);
        put_item(FN_NOTE_ON, 3'd4, WV_NOISE, 16'd1, 9'd256);
        put_item(FN_NOTE_ON, 3'd5, 3'd5, 16'd300, 9'd256);
        put_item(FN_NOTE_ON, 3'd6, 3'd7, 16'h8000, 9'd0);
        put_item(FN_NOTE_ON, 3'd7, WV_NOISE, 16'h5555, 9'h1FF);
        repeat (6) put_item(FN_TICK, 3'd0, 3'd0, 16'd0, 9'd0);
        put_item(FN_KEY_OFF, 3'd1, 3'd0, 16'd0, 9'd0);
        put_item(FN_NOTE_ON, 3'd1, WV_SAW, 16'd700, 9'd256);
        repeat (4) put_item(FN_TICK, 3'd0, 3'd0, 16'd0, 9'd0);
        random_items(250);
        drain_samples();

        write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        random_items(230);
        drain_samples();
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_items(230);
        drain_samples();
        write_all(16'hFFFF, 16'd1, 16'd0, 16'hFFFF);
        random_items(230);
        drain_samples();
        write_all(16'd9000, 16'd4000, 16'd20000, 16'd3000);
        random_items(230);
        drain_samples();
        write_all(pick16(), pick16(), pick16(), pick16());
        random_items(230);
        drain_samples();
        write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        random_items(230);
        drain_samples();

        if (sb.errors == 0 && sb.pending_samples.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> filelist.f
design/amx_pkg.sv
design/amx_if.sv
design/amx_ctrl.sv
design/amx_datapath.sv
design/adsr_wavetable_voice_mixer.sv
tb/adsr_wavetable_voice_mixer_test.sv
